/* design/ird_pkg.sv */
package ird_pkg;

	// Table geometry.
	localparam int PROFILE_LEN  = 64;
	localparam int SENSOR_COUNT = 4;
	localparam int IDX_W        = $clog2(PROFILE_LEN);
	localparam int SIDX_W       = (SENSOR_COUNT > 1) ? $clog2(SENSOR_COUNT) : 1;
	localparam int ADDR_W       = $clog2(SENSOR_COUNT * PROFILE_LEN);
	localparam int PROF_DEPTH   = SENSOR_COUNT * PROFILE_LEN;
	localparam int LAST_SEG     = PROFILE_LEN - 2;

	// Field widths.
	localparam int FUNC_W  = 1;
	localparam int SEN_W   = 2;
	localparam int ENTRY_W = 6;
	localparam int LEVEL_W = 12;
	localparam int DIST_W  = 18;
	localparam int SEG_W   = 6;
	localparam int STAT_W  = 2;
	localparam int MPC_W   = 8;

	localparam logic [MPC_W-1:0] MPC_RESET = MPC_W'(5);

	// Arithmetic widths: the quotient is at most 16 * mm_per_cell.
	localparam int QUO_W  = MPC_W + 4;
	localparam int NUM_W  = MPC_W + LEVEL_W + 4;
	localparam int WIDE_W = IDX_W + 1 + MPC_W + 4 + 1;
	localparam logic [WIDE_W-1:0] DIST_MAX = WIDE_W'((1 << DIST_W) - 1);

	// Function codes.
	localparam logic [FUNC_W-1:0] FN_LOAD    = 1'b0;
	localparam logic [FUNC_W-1:0] FN_CONVERT = 1'b1;

	// Status codes.
	localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
	localparam logic [STAT_W-1:0] ST_FAR  = 2'd1;
	localparam logic [STAT_W-1:0] ST_NEAR = 2'd2;
	localparam logic [STAT_W-1:0] ST_FLAT = 2'd3;

	// Command passed from the front end to the back end.
	typedef struct packed {
		logic               is_load;
		logic [SEN_W-1:0]   sensor;
		logic [IDX_W-1:0]   entry;
		logic [LEVEL_W-1:0] level;
	} cmd_t;

	// Saturate a wide distance to the output width.
	function automatic logic [DIST_W-1:0] sat_dist(input logic [WIDE_W-1:0] d);
		logic [DIST_W-1:0] r;
		if (d > DIST_MAX) begin
			r = '1;
		end else begin
			r = d[DIST_W-1:0];
		end
		return r;
	endfunction

endpackage

/* design/ird_if.sv */
// Sample and load channel.
interface ird_req_if;
	logic                         valid;
	logic                         ready;
	logic [ird_pkg::FUNC_W-1:0]   func;
	logic [ird_pkg::SEN_W-1:0]    sensor;
	logic [ird_pkg::ENTRY_W-1:0]  entry_index;
	logic [ird_pkg::LEVEL_W-1:0]  level;
	modport source (output valid, func, sensor, entry_index, level, input ready);
	modport sink (input valid, func, sensor, entry_index, level, output ready);
endinterface

// Result channel.
interface ird_rsp_if;
	logic                        valid;
	logic                        ready;
	logic [ird_pkg::SEN_W-1:0]   sensor_out;
	logic [ird_pkg::DIST_W-1:0]  distance;
	logic [ird_pkg::SEG_W-1:0]   segment;
	logic [ird_pkg::STAT_W-1:0]  status;
	modport source (output valid, sensor_out, distance, segment, status, input ready);
	modport sink (input valid, sensor_out, distance, segment, status, output ready);
endinterface

// Register write channel.
interface ird_cfg_if;
	logic                       valid;
	logic                       ready;
	logic [ird_pkg::MPC_W-1:0]  data;
	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

/* design/ir_distance_linearizer_top.sv */
// IR distance linearizer.
// The req channel takes two kinds of transaction: func 0 loads one level into a
// sensor's calibration profile, func 1 converts a sample into a distance. Only
// conversions produce a transaction on the rsp channel, in arrival order.
// The cfg channel writes mm_per_cell; it is always ready and takes effect at
// once, so write it only while no conversion is in flight.
// Every transaction passes the holding stage and the queue; a load is written
// when the back end takes it, and a sample equal to the sensor's previous one
// goes straight to the result. Any other sample walks k segments, each one
// memory read and one compare. A sample that lands inside a segment then takes
// a 12-bit bit-serial division and a sum; a clamped, flat or out-of-range
// outcome skips the division.
// The back end works one transaction at a time and takes the next one from the
// queue only in its idle state, which a conversion reaches after offering a result.
// A holding stage and a two-entry queue sit in front of the back end, so the
// req side keeps accepting while a result waits on rsp; once they fill while
// rsp stalls, the back end holds its result and req.ready falls.
// Reset clears the tracking state of every sensor (segment at the far end,
// previous sample and result zero) and sets mm_per_cell to 5. Profile contents
// are not cleared and must be loaded before use.
module ir_distance_linearizer_top (
	input  logic     clk,
	input  logic     arst_n,
	ird_req_if.sink  req,
	ird_rsp_if.source rsp,
	ird_cfg_if.sink  cfg
);

	logic [ird_pkg::MPC_W-1:0] mm_per_cell_q;
	logic                      push;
	ird_pkg::cmd_t             push_cmd;
	logic                      fifo_full;
	logic                      pop;
	ird_pkg::cmd_t             pop_cmd;
	logic                      fifo_empty;

	// Cell size register.
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mm_per_cell_q <= ird_pkg::MPC_RESET;
		end else if (cfg.valid && cfg.ready) begin
			mm_per_cell_q <= cfg.data;
		end
	end

	ird_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.fifo_full (fifo_full),
		.push      (push),
		.push_cmd  (push_cmd)
	);

	ird_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.full     (fifo_full),
		.pop      (pop),
		.pop_cmd  (pop_cmd),
		.empty    (fifo_empty)
	);

	ird_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.mm_per_cell (mm_per_cell_q),
		.empty       (fifo_empty),
		.pop_cmd     (pop_cmd),
		.pop         (pop),
		.rsp         (rsp)
	);

endmodule

/* design/ird_front.sv */
module ird_front (
	input  logic             clk,
	input  logic             arst_n,
	ird_req_if.sink          req,
	input  logic             fifo_full,
	output logic             push,
	output ird_pkg::cmd_t    push_cmd
);

	ird_pkg::cmd_t cmd_s1;
	logic          v_s1;
	logic          accept;
	logic          keep;
	logic          sensor_ok;
	logic          entry_ok;

	// Drop transactions for absent sensors and loads beyond the table.
	assign sensor_ok = (32'(req.sensor) < ird_pkg::SENSOR_COUNT);
	assign entry_ok  = (32'(req.entry_index) < ird_pkg::PROFILE_LEN);
	assign keep      = sensor_ok && ((req.func == ird_pkg::FN_CONVERT) || entry_ok);

	assign req.ready = !v_s1 || !fifo_full;
	assign accept    = req.valid && req.ready;
	assign push      = v_s1 && !fifo_full;
	assign push_cmd  = cmd_s1;

	// Holding stage in front of the queue.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= (v_s1 && fifo_full) || (accept && keep);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1.is_load <= (req.func == ird_pkg::FN_LOAD);
			cmd_s1.sensor  <= req.sensor;
			cmd_s1.entry   <= ird_pkg::IDX_W'(req.entry_index);
			cmd_s1.level   <= req.level;
		end
	end

endmodule

/* design/ird_fifo.sv */
module ird_fifo (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  ird_pkg::cmd_t    push_cmd,
	output logic             full,
	input  logic             pop,
	output ird_pkg::cmd_t    pop_cmd,
	output logic             empty
);

	ird_pkg::cmd_t slot_q [2];
	logic          wr_q;
	logic          rd_q;
	logic [1:0]    cnt_q;

	assign full    = (cnt_q == 2'd2);
	assign empty   = (cnt_q == 2'd0);
	assign pop_cmd = slot_q[rd_q];

	// Two-entry circular queue.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= !wr_q;
			end
			if (pop) begin
				rd_q <= !rd_q;
			end
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= push_cmd;
		end
	end

endmodule

/* design/ird_back.sv */
module ird_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [ird_pkg::MPC_W-1:0]   mm_per_cell,
	input  logic                        empty,
	input  ird_pkg::cmd_t               pop_cmd,
	output logic                        pop,
	ird_rsp_if.source                   rsp
);

	typedef enum logic [5:0] {
		S_IDLE  = 6'b000001,
		S_READ  = 6'b000010,
		S_CHECK = 6'b000100,
		S_DIV   = 6'b001000,
		S_SUM   = 6'b010000,
		S_EMIT  = 6'b100000
	} state_t;

	localparam int CNT_W = $clog2(ird_pkg::QUO_W + 1);

	state_t state_q;

	// Per-sensor tracking state.
	logic [ird_pkg::IDX_W-1:0]   seg_q      [ird_pkg::SENSOR_COUNT];
	logic [ird_pkg::LEVEL_W-1:0] lastlvl_q  [ird_pkg::SENSOR_COUNT];
	logic [ird_pkg::DIST_W-1:0]  lastdist_q [ird_pkg::SENSOR_COUNT];
	logic [ird_pkg::STAT_W-1:0]  laststat_q [ird_pkg::SENSOR_COUNT];

	// Profile memory.
	logic [ird_pkg::LEVEL_W-1:0] mem [ird_pkg::PROF_DEPTH];
	logic [ird_pkg::LEVEL_W-1:0] ya_q;
	logic [ird_pkg::LEVEL_W-1:0] yb_q;

	// Working registers of the current sample.
	logic [ird_pkg::SEN_W-1:0]   sen_q;
	logic [ird_pkg::LEVEL_W-1:0] x_q;
	logic [ird_pkg::IDX_W-1:0]   idx_q;
	logic                        down_q;
	logic                        upd_q;
	logic [ird_pkg::WIDE_W-1:0]  base_q;
	logic [ird_pkg::LEVEL_W-1:0] den_q;
	logic [ird_pkg::LEVEL_W-1:0] rem_q;
	logic [ird_pkg::QUO_W-1:0]   low_q;
	logic [CNT_W-1:0]            cnt_q;
	logic [ird_pkg::DIST_W-1:0]  res_dist_q;
	logic [ird_pkg::STAT_W-1:0]  res_stat_q;

	logic [ird_pkg::SIDX_W-1:0]  cs;
	logic [ird_pkg::SIDX_W-1:0]  ws;
	logic [ird_pkg::ADDR_W-1:0]  sbase;
	logic [ird_pkg::ADDR_W-1:0]  rd0;
	logic [ird_pkg::ADDR_W-1:0]  rd1;
	logic [ird_pkg::ADDR_W-1:0]  wr_addr;
	logic                        wr_en;
	logic                        bracket;
	logic                        at_end;
	logic [ird_pkg::WIDE_W-1:0]  base_now;
	logic [ird_pkg::WIDE_W-1:0]  cell_len;
	logic [ird_pkg::NUM_W-1:0]   num;
	logic [ird_pkg::LEVEL_W:0]   trial;
	logic                        qbit;
	logic                        out_free;
	logic                        emit;

	assign cs  = ird_pkg::SIDX_W'(pop_cmd.sensor);
	assign ws  = ird_pkg::SIDX_W'(sen_q);

	// Memory addresses: sensor row plus entry.
	assign sbase   = ird_pkg::ADDR_W'(ird_pkg::ADDR_W'(sen_q)
		* ird_pkg::ADDR_W'(ird_pkg::PROFILE_LEN));
	assign rd0     = sbase + ird_pkg::ADDR_W'(idx_q);
	assign rd1     = sbase + ird_pkg::ADDR_W'(idx_q) + ird_pkg::ADDR_W'(1);
	assign wr_addr = ird_pkg::ADDR_W'(ird_pkg::ADDR_W'(pop_cmd.sensor)
		* ird_pkg::ADDR_W'(ird_pkg::PROFILE_LEN)) + ird_pkg::ADDR_W'(pop_cmd.entry);

	assign pop   = (state_q == S_IDLE) && !empty;
	assign wr_en = pop && pop_cmd.is_load;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= pop_cmd.level;
		end
		ya_q <= mem[rd0];
		yb_q <= mem[rd1];
	end

	// Walk test and segment arithmetic.
	assign bracket  = !((x_q > ya_q) || (x_q < yb_q));
	assign at_end   = down_q ? (idx_q == '0)
		: (32'(idx_q) >= ird_pkg::LAST_SEG);
	assign cell_len = ird_pkg::WIDE_W'({mm_per_cell, 4'b0000});
	assign base_now = ird_pkg::WIDE_W'(ird_pkg::WIDE_W'(idx_q) * cell_len);
	assign num      = ird_pkg::NUM_W'({ird_pkg::NUM_W'(mm_per_cell
		* (ya_q - x_q)), 4'b0000});

	// One restoring division step.
	assign trial = {rem_q, low_q[ird_pkg::QUO_W-1]};
	assign qbit  = (trial >= {1'b0, den_q});

	assign out_free = !rsp.valid || rsp.ready;
	assign emit     = (state_q == S_EMIT) && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			for (int i = 0; i < ird_pkg::SENSOR_COUNT; i++) begin
				seg_q[i]      <= ird_pkg::IDX_W'(ird_pkg::LAST_SEG);
				lastlvl_q[i]  <= '0;
				lastdist_q[i] <= '0;
				laststat_q[i] <= ird_pkg::ST_OK;
			end
			rsp.valid <= 1'b0;
		end else begin
			// Offer a new result, or drop the one just taken.
			if (emit) begin
				rsp.valid <= 1'b1;
			end else if (rsp.valid && rsp.ready) begin
				rsp.valid <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (pop && !pop_cmd.is_load) begin
						if (pop_cmd.level == lastlvl_q[cs]) begin
							state_q <= S_EMIT;
						end else begin
							state_q <= S_READ;
						end
					end
				end
				S_READ: begin
					state_q <= S_CHECK;
				end
				S_CHECK: begin
					if (bracket || at_end) begin
						if ((ya_q > yb_q) && bracket) begin
							state_q <= S_DIV;
						end else begin
							state_q <= S_EMIT;
						end
					end else begin
						state_q <= S_READ;
					end
				end
				S_DIV: begin
					if (cnt_q == CNT_W'(1)) begin
						state_q <= S_SUM;
					end
				end
				S_SUM: begin
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					if (out_free) begin
						state_q   <= S_IDLE;
						if (upd_q) begin
							seg_q[ws]      <= idx_q;
							lastlvl_q[ws]  <= x_q;
							lastdist_q[ws] <= res_dist_q;
							laststat_q[ws] <= res_stat_q;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				sen_q  <= pop_cmd.sensor;
				x_q    <= pop_cmd.level;
				idx_q  <= seg_q[cs];
				down_q <= pop_cmd.level > lastlvl_q[cs];
				upd_q  <= (pop_cmd.level != lastlvl_q[cs]);
				res_dist_q <= lastdist_q[cs];
				res_stat_q <= laststat_q[cs];
			end
			S_READ: begin
			end
			S_CHECK: begin
				if (bracket || at_end) begin
					base_q <= base_now;
					den_q  <= ya_q - yb_q;
					rem_q  <= num[ird_pkg::NUM_W-1:ird_pkg::QUO_W];
					low_q  <= num[ird_pkg::QUO_W-1:0];
					cnt_q  <= CNT_W'(ird_pkg::QUO_W);
					if (ya_q <= yb_q) begin
						res_stat_q <= ird_pkg::ST_FLAT;
						res_dist_q <= ird_pkg::sat_dist(base_now);
					end else if (x_q > ya_q) begin
						res_stat_q <= ird_pkg::ST_NEAR;
						res_dist_q <= ird_pkg::sat_dist(base_now);
					end else if (x_q < yb_q) begin
						res_stat_q <= ird_pkg::ST_FAR;
						res_dist_q <= ird_pkg::sat_dist(base_now + cell_len);
					end else begin
						res_stat_q <= ird_pkg::ST_OK;
					end
				end else if (down_q) begin
					idx_q <= idx_q - ird_pkg::IDX_W'(1);
				end else begin
					idx_q <= idx_q + ird_pkg::IDX_W'(1);
				end
			end
			S_DIV: begin
				rem_q <= qbit ? ird_pkg::LEVEL_W'(trial - {1'b0, den_q})
					: trial[ird_pkg::LEVEL_W-1:0];
				low_q <= {low_q[ird_pkg::QUO_W-2:0], qbit};
				cnt_q <= cnt_q - CNT_W'(1);
			end
			S_SUM: begin
				res_dist_q <= ird_pkg::sat_dist(base_q + ird_pkg::WIDE_W'(low_q));
			end
			S_EMIT: begin
			end
			default: begin
			end
		endcase
	end

	// Result register.
	always_ff @(posedge clk) begin
		if (emit) begin
			rsp.sensor_out <= sen_q;
			rsp.distance   <= res_dist_q;
			rsp.segment    <= ird_pkg::SEG_W'(upd_q ? idx_q : seg_q[ws]);
			rsp.status     <= res_stat_q;
		end
	end

endmodule

/* design/ird_checker.sv */
module ird_checker (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        rsp_valid,
	input  logic                        rsp_ready,
	input  logic [ird_pkg::DIST_W-1:0]  rsp_distance,
	input  logic [ird_pkg::SEG_W-1:0]   rsp_segment,
	input  logic [ird_pkg::STAT_W-1:0]  rsp_status,
	input  logic                        cfg_ready
);

	// A stalled result stays offered.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("rsp valid dropped while stalled");

	// A stalled result keeps its distance.
	a_stable: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> $stable(rsp_distance))
		else $error("rsp distance changed while stalled");

	// A sample nearer than the first segment reports distance zero.
	a_near0: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_status == ird_pkg::ST_NEAR && rsp_segment == '0
		|-> rsp_distance == '0)
		else $error("near result at first segment is not zero");

	// Register writes are never stalled.
	a_cfg: assert property (@(posedge clk) disable iff (!arst_n) cfg_ready)
		else $error("cfg channel not ready");

endmodule

bind ir_distance_linearizer_top ird_checker u_ird_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.rsp_valid    (rsp.valid),
	.rsp_ready    (rsp.ready),
	.rsp_distance (rsp.distance),
	.rsp_segment  (rsp.segment),
	.rsp_status   (rsp.status),
	.cfg_ready    (cfg.ready)
);

/* bench/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;

	localparam int QUIET_LIMIT = 5000;
	localparam int DRAIN_WAIT  = 40;
	localparam int LONG_STALL  = 400;

	typedef struct packed {
		logic [ird_pkg::FUNC_W-1:0]  func;
		logic [ird_pkg::SEN_W-1:0]   sensor;
		logic [ird_pkg::ENTRY_W-1:0] entry_index;
		logic [ird_pkg::LEVEL_W-1:0] level;
	} sample_t;

	typedef struct packed {
		logic [ird_pkg::SEN_W-1:0]  sensor;
		logic [ird_pkg::DIST_W-1:0] distance;
		logic [ird_pkg::SEG_W-1:0]  segment;
		logic [ird_pkg::STAT_W-1:0] status;
	} reading_t;

	logic clk;
	logic arst_n;

	ird_req_if req ();
	ird_rsp_if rsp ();
	ird_cfg_if cfg ();

	ir_distance_linearizer_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp),
		.cfg    (cfg)
	);

	// Shadow copy of the calibration tables, tracking state and cell size.
	logic [ird_pkg::LEVEL_W-1:0] cal_level [ird_pkg::SENSOR_COUNT][ird_pkg::PROFILE_LEN];
	int                          track_seg [ird_pkg::SENSOR_COUNT];
	logic [ird_pkg::LEVEL_W-1:0] prev_level [ird_pkg::SENSOR_COUNT];
	logic [ird_pkg::DIST_W-1:0]  prev_dist [ird_pkg::SENSOR_COUNT];
	logic [ird_pkg::STAT_W-1:0]  prev_status [ird_pkg::SENSOR_COUNT];
	logic [ird_pkg::MPC_W-1:0]   cell_mm;

	sample_t  send_queue [$];
	reading_t expected_readings [$];
	logic [ird_pkg::LEVEL_W-1:0] gen_last [ird_pkg::SENSOR_COUNT];

	int src_idle_pct;
	int sink_idle_pct;
	bit hold_send;
	bit long_stall_go;
	bit stall_done;
	int hold_rsp_cycles;
	int quiet_cycles;
	int errors = 0;
	int n_loads = 0;
	int n_readings = 0;
	int status_seen [4] = '{default: 0};

	// Convert one accepted transaction; returns 1 when it yields a reading.
	function automatic bit convert_sample(input sample_t t, output reading_t r);
		int s;
		int i;
		int ya;
		int yb;
		bit down;
		longint dist_v;
		logic [ird_pkg::STAT_W-1:0] st;
		s = t.sensor;
		r = '0;
		if (t.func == ird_pkg::FN_LOAD) begin
			cal_level[s][t.entry_index] = t.level;
			return 0;
		end
		if (t.level == prev_level[s]) begin
			r = '{t.sensor, prev_dist[s], ird_pkg::SEG_W'(track_seg[s]), prev_status[s]};
			return 1;
		end
		down = t.level > prev_level[s];
		i = track_seg[s];
		if (i > ird_pkg::LAST_SEG) i = ird_pkg::LAST_SEG;
		// Walk the segment index until the sample is bracketed or it clamps.
		while (t.level > cal_level[s][i] || t.level < cal_level[s][i+1]) begin
			if (down) begin
				if (i == 0) break;
				i--;
			end else begin
				if (i >= ird_pkg::LAST_SEG) break;
				i++;
			end
		end
		ya = cal_level[s][i];
		yb = cal_level[s][i+1];
		dist_v = longint'(16) * i * cell_mm;
		if (ya <= yb) begin
			st = ird_pkg::ST_FLAT;
		end else if (t.level > ya) begin
			st = ird_pkg::ST_NEAR;
		end else if (t.level < yb) begin
			st = ird_pkg::ST_FAR;
			dist_v = longint'(16) * (i + 1) * cell_mm;
		end else begin
			st = ird_pkg::ST_OK;
			dist_v = dist_v + (longint'(16) * cell_mm * (ya - t.level)) / (ya - yb);
		end
		if (dist_v > 262143) dist_v = 262143;
		track_seg[s] = i;
		prev_level[s] = t.level;
		prev_dist[s] = ird_pkg::DIST_W'(dist_v);
		prev_status[s] = st;
		r = '{t.sensor, ird_pkg::DIST_W'(dist_v), ird_pkg::SEG_W'(i), st};
		return 1;
	endfunction

	// Clock.
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Driver: presents queued transactions and predicts each one on acceptance.
	always @(posedge clk) begin
		reading_t r;
		sample_t t;
		if (!arst_n) begin
			req.valid       <= 1'b0;
			req.func        <= ird_pkg::FN_LOAD;
			req.sensor      <= '0;
			req.entry_index <= '0;
			req.level       <= '0;
			for (int s = 0; s < ird_pkg::SENSOR_COUNT; s++) begin
				track_seg[s] = ird_pkg::LAST_SEG;
				prev_level[s] = '0;
				prev_dist[s] = '0;
				prev_status[s] = ird_pkg::ST_OK;
			end
		end else begin
			if (req.valid && req.ready) begin
				t = '{req.func, req.sensor, req.entry_index, req.level};
				if (convert_sample(t, r)) expected_readings.push_back(r);
				else n_loads++;
			end
			if (!(req.valid && !req.ready)) begin
				if (send_queue.size() > 0 && !hold_send &&
				    $urandom_range(99) >= src_idle_pct) begin
					t = send_queue.pop_front();
					req.valid       <= 1'b1;
					req.func        <= t.func;
					req.sensor      <= t.sensor;
					req.entry_index <= t.entry_index;
					req.level       <= t.level;
				end else begin
					req.valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: checks every reading against the oldest prediction.
	always @(posedge clk) begin
		reading_t e;
		if (!arst_n) begin
			rsp.ready    <= 1'b0;
			quiet_cycles <= 0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				if (expected_readings.size() == 0) begin
					$error("reading with nothing expected: sensor %0d distance %0d",
					       rsp.sensor_out, rsp.distance);
					errors++;
				end else begin
					e = expected_readings.pop_front();
					n_readings++;
					status_seen[rsp.status]++;
					if (rsp.sensor_out !== e.sensor) begin
						$error("sensor_out expected %0d actual %0d", e.sensor, rsp.sensor_out);
						errors++;
					end
					if (rsp.distance !== e.distance) begin
						$error("distance expected %0d actual %0d", e.distance, rsp.distance);
						errors++;
					end
					if (rsp.segment !== e.segment) begin
						$error("segment expected %0d actual %0d", e.segment, rsp.segment);
						errors++;
					end
					if (rsp.status !== e.status) begin
						$error("status expected %0d actual %0d", e.status, rsp.status);
						errors++;
					end
				end
			end
			rsp.ready <= (hold_rsp_cycles == 0) && ($urandom_range(99) >= sink_idle_pct);
			if ((req.valid && req.ready) || (rsp.valid && rsp.ready) ||
			    (cfg.valid && cfg.ready)) begin
				quiet_cycles <= 0;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
			if (quiet_cycles > QUIET_LIMIT) begin
				$display("SCOREBOARD MISMATCH");
				$finish;
			end
		end
	end

	// Long receiver stall, loaded once on request and counted down here.
	always @(posedge clk) begin
		if (!arst_n) begin
			hold_rsp_cycles <= 0;
			stall_done      <= 1'b0;
		end else if (long_stall_go && !stall_done) begin
			hold_rsp_cycles <= LONG_STALL;
			stall_done      <= 1'b1;
		end else if (hold_rsp_cycles > 0) begin
			hold_rsp_cycles <= hold_rsp_cycles - 1;
		end
	end

	task automatic push_item(input logic [ird_pkg::FUNC_W-1:0] f, input int s, input int e,
	                         input int lvl);
		sample_t t;
		t = '{f, ird_pkg::SEN_W'(s), ird_pkg::ENTRY_W'(e), ird_pkg::LEVEL_W'(lvl)};
		@(negedge clk);
		send_queue.push_back(t);
		if (f == ird_pkg::FN_CONVERT) gen_last[s] = ird_pkg::LEVEL_W'(lvl);
	endtask

	// Fill one sensor's calibration table with a chosen shape.
	task automatic load_table(input int s, input int shape);
		int lvl;
		for (int e = 0; e < ird_pkg::PROFILE_LEN; e++) begin
			case (shape)
				0: lvl = 4000 - e * 60;
				1: lvl = 3900 - (e / 2) * 110;
				2: lvl = (e == 20) ? 2000 : 3800 - e * 55;
				default: lvl = (e == 0 || e == ird_pkg::PROFILE_LEN - 1) ? 4095 - e * 65 :
				               4095 - e * 65 + $urandom_range(40) - 20;
			endcase
			push_item(ird_pkg::FN_LOAD, s, e, lvl);
		end
	endtask

	task automatic wait_drained();
		do @(negedge clk);
		while (send_queue.size() != 0 || req.valid || expected_readings.size() != 0);
		repeat (DRAIN_WAIT) @(negedge clk);
	endtask

	task automatic write_cell_mm(input logic [ird_pkg::MPC_W-1:0] v);
		@(posedge clk);
		cfg.valid <= 1'b1;
		cfg.data  <= v;
		do @(posedge clk);
		while (!cfg.ready);
		cfg.valid <= 1'b0;
		cell_mm = v;
	endtask

	task automatic random_phase(input int count);
		int s;
		int lvl;
		int pick;
		for (int n = 0; n < count; n++) begin
			s = $urandom_range(ird_pkg::SENSOR_COUNT - 1);
			pick = $urandom_range(99);
			if (pick < 8) begin
				push_item(ird_pkg::FN_LOAD, s, $urandom_range(ird_pkg::PROFILE_LEN - 1),
				          $urandom_range(4095));
			end else begin
				if (pick < 22) begin
					lvl = gen_last[s];
				end else if (pick < 55) begin
					lvl = int'(gen_last[s]) + $urandom_range(80) - 40;
					if (lvl < 0) lvl = 0;
					if (lvl > 4095) lvl = 4095;
				end else if (pick < 62) begin
					lvl = ($urandom_range(1) != 0) ? 4095 : 0;
				end else begin
					lvl = $urandom_range(4095);
				end
				push_item(ird_pkg::FN_CONVERT, s, $urandom_range(ird_pkg::PROFILE_LEN - 1),
				          lvl);
			end
		end
	endtask

	// Stimulus and end of run.
	initial begin
		arst_n = 1'b0;
		cfg.valid = 1'b0;
		cfg.data = '0;
		hold_send = 1'b0;
		long_stall_go = 1'b0;
		src_idle_pct = 7;
		sink_idle_pct = 62;
		cell_mm = ird_pkg::MPC_RESET;
		for (int s = 0; s < ird_pkg::SENSOR_COUNT; s++) begin
			gen_last[s] = '0;
		end
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// A zero sample right after reset repeats the reset reading.
		push_item(ird_pkg::FN_CONVERT, 0, 0, 0);
		load_table(0, 0);
		load_table(1, 1);
		load_table(2, 2);
		load_table(3, 3);

		// Directed conversions: table ends, exact entries, repeats, flat and rising.
		push_item(ird_pkg::FN_CONVERT, 0, 0, 4095);
		push_item(ird_pkg::FN_CONVERT, 0, 63, 0);
		push_item(ird_pkg::FN_CONVERT, 0, 0, 4000);
		push_item(ird_pkg::FN_CONVERT, 0, 0, 2003);
		push_item(ird_pkg::FN_CONVERT, 0, 0, 2003);
		push_item(ird_pkg::FN_CONVERT, 1, 0, 3790);
		push_item(ird_pkg::FN_CONVERT, 1, 0, 500);
		push_item(ird_pkg::FN_CONVERT, 2, 0, 2700);
		push_item(ird_pkg::FN_CONVERT, 2, 0, 2001);
		push_item(ird_pkg::FN_CONVERT, 3, 0, 0);
		push_item(ird_pkg::FN_CONVERT, 3, 0, 4095);
		push_item(ird_pkg::FN_CONVERT, 3, 42, 1234);
		wait_drained();

		// Random phases across cell sizes, idle patterns and a long stall.
		write_cell_mm(ird_pkg::MPC_W'(1));
		random_phase(260);
		wait_drained();
		write_cell_mm(ird_pkg::MPC_W'(255));
		src_idle_pct = 62;
		sink_idle_pct = 7;
		random_phase(260);
		wait_drained();
		write_cell_mm(ird_pkg::MPC_W'($urandom_range(2, 254)));
		src_idle_pct = 0;
		sink_idle_pct = 0;
		long_stall_go = 1'b1;
		random_phase(110);
		// Wait until every pending reading has come back, then hold the sender.
		wait_drained();
		hold_send = 1'b1;
		repeat (20) @(negedge clk);
		hold_send = 1'b0;
		random_phase(110);
		wait_drained();

		$display("Covered %0d table loads and %0d readings over cell sizes 5, 1, 255, random.",
		         n_loads, n_readings);
		$display("Statuses seen: ok %0d, far %0d, near %0d, flat %0d.",
		         status_seen[0], status_seen[1], status_seen[2], status_seen[3]);
		if (errors == 0 && expected_readings.size() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
